FILE: design/stsid_pkg.sv
// Package: shared types and constants for the sorted table search/insert/delete block.
`default_nettype none
package stsid_pkg;

  // Command codes
  localparam logic [1:0] CMD_SEARCH = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_GAP    = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // Configuration port
  localparam int unsigned PADDR_W      = 3;
  localparam logic        REG_CAP_IDX  = 1'b0;
  localparam logic [8:0]  CAP_RESET    = 9'd256;

  // Field widths
  localparam int unsigned POS_W = 9;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: design/stsid_if.sv
// Interfaces: command channel and result channel, valid/ready handshake.
`default_nettype none
interface stsid_req_if;
  import stsid_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] key;
  logic [POS_W-1:0]   position;
  logic signed [31:0] start_value;

  modport source (output valid, cmd, key, position, start_value, input ready);
  modport sink   (input valid, cmd, key, position, start_value, output ready);
endinterface

interface stsid_rsp_if;
  import stsid_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [POS_W-1:0]   index;
  logic signed [31:0] next_value;
  logic [1:0]         status;

  modport source (output valid, found, index, next_value, status, input ready);
  modport sink   (input valid, found, index, next_value, status, output ready);
endinterface
`default_nettype wire

FILE: design/sorted_table_search_insert_delete.sv
// Top level: sorted table of signed words with search, first-gap, insert and delete.
// Usage:
//   req channel carries one command item (cmd, key, position, start_value);
//   rsp channel returns exactly one result item (found, index, next_value,
//   status) per command. Both use valid/ready; an item moves when both are high.
//   The APB port holds capacity_limit at byte address 0 (reset 256).
// Operation, with p the position:
//   search / first gap: a hit stops the scan early. One memory read port
//     streams one entry per cycle and a single compare unit checks it in
//     the cycle after.
//   insert and delete move the entries from p on by one place.
//     Each moved entry takes one read and one write on the table memory, overlapped.
//   Rejected insert or delete (full, bad position): no entry is moved.
// req.ready is high only while the sequencer is idle; one command runs at a
// time. A finished result waits in the output register while the receiver
// stalls, and the next command may already be accepted in that time; the
// sequencer holds its next result until the output register is free.
// Reset clears the entry count, the sequencer and the output valid and sets
// capacity_limit to 256; table contents are not cleared.
`default_nettype none
module sorted_table_search_insert_delete
  import stsid_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  stsid_req_if.sink               req,
  stsid_rsp_if.source             rsp,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  // Configuration register
  logic [8:0] cap_limit;
  logic       cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[PADDR_W-1:2] == REG_CAP_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= CAP_RESET;
    end else if (psel && penable && pwrite && cfg_hit) begin
      cap_limit <= pwdata[8:0];
    end
  end

  assign prdata = cfg_hit ? {23'd0, cap_limit} : 32'd0;

  // Table memory: one write port, one registered read port
  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_data;
  logic [AW-1:0] ra;
  logic [AW-1:0] wa;
  logic [31:0]   wd;
  logic          we;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  // Sequencer and datapath registers
  state_t             state, state_next;
  logic [1:0]         cmd_r, cmd_r_next;
  logic signed [31:0] key_r, key_r_next;
  logic signed [31:0] val, val_next;
  logic [CW-1:0]      pos_r, pos_r_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      ptr, ptr_next;
  logic               dv, dv_next;
  logic               pend, pend_next;
  logic [AW-1:0]      pend_addr, pend_addr_next;
  logic               res_found, res_found_next;
  logic [POS_W-1:0]   res_index, res_index_next;
  logic [1:0]         res_status, res_status_next;

  logic               out_valid, out_valid_next;
  logic               out_found, out_found_next;
  logic [POS_W-1:0]   out_index, out_index_next;
  logic signed [31:0] out_value, out_value_next;
  logic [1:0]         out_status, out_status_next;

  logic [CMPW-1:0]    pos_ext, cnt_ext;
  logic               full;
  logic               scan_hit;

  assign pos_ext = CMPW'(req.position);
  assign cnt_ext = CMPW'(count);
  assign full    = (cnt_ext >= CMPW'(cap_limit)) || (count >= CW'(DEPTH));

  // Compare unit: one entry against the key or the running value
  always_comb begin
    if (cmd_r == CMD_GAP) begin
      scan_hit = (val < $signed(rd_data));
    end else begin
      scan_hit = ($signed(rd_data) == key_r) || (key_r < $signed(rd_data));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      dv        <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dv        <= dv_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_r_next;
    key_r      <= key_r_next;
    val        <= val_next;
    pos_r      <= pos_r_next;
    ptr        <= ptr_next;
    pend_addr  <= pend_addr_next;
    res_found  <= res_found_next;
    res_index  <= res_index_next;
    res_status <= res_status_next;
    out_found  <= out_found_next;
    out_index  <= out_index_next;
    out_value  <= out_value_next;
    out_status <= out_status_next;
  end

  // Next state and outputs
  always_comb begin
    state_next      = state;
    cmd_r_next      = cmd_r;
    key_r_next      = key_r;
    val_next        = val;
    pos_r_next      = pos_r;
    count_next      = count;
    ptr_next        = ptr;
    dv_next         = 1'b0;
    pend_next       = 1'b0;
    pend_addr_next  = pend_addr;
    res_found_next  = res_found;
    res_index_next  = res_index;
    res_status_next = res_status;
    out_found_next  = out_found;
    out_index_next  = out_index;
    out_value_next  = out_value;
    out_status_next = out_status;
    out_valid_next  = out_valid && !rsp.ready;
    req.ready       = 1'b0;
    ra              = ptr[AW-1:0];
    we              = 1'b0;
    wa              = pend_addr;
    wd              = rd_data;

    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          cmd_r_next      = req.cmd;
          key_r_next      = req.key;
          val_next        = req.start_value;
          pos_r_next      = CW'(req.position);
          res_found_next  = 1'b0;
          res_index_next  = '0;
          res_status_next = STATUS_OK;
          ptr_next        = '0;
          case (req.cmd)
            CMD_INSERT: begin
              if (full) begin
                res_status_next = STATUS_FULL;
                state_next      = ST_DONE;
              end else if (pos_ext > cnt_ext) begin
                res_status_next = STATUS_RANGE;
                state_next      = ST_DONE;
              end else begin
                ptr_next   = count;
                state_next = ST_SHIFT;
              end
            end
            CMD_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                res_status_next = STATUS_RANGE;
                state_next      = ST_DONE;
              end else begin
                ptr_next   = CW'(req.position);
                state_next = ST_SHIFT;
              end
            end
            default: begin
              state_next = ST_SCAN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // issue the next read while the previous entry is compared
        if (ptr < count) begin
          ptr_next = ptr + 1'b1;
          dv_next  = 1'b1;
        end
        if (dv) begin
          if (scan_hit) begin
            res_found_next = (cmd_r != CMD_GAP) && ($signed(rd_data) == key_r);
            res_index_next = POS_W'(ptr - 1'b1);
            dv_next        = 1'b0;
            state_next     = ST_DONE;
          end else if (cmd_r == CMD_GAP) begin
            val_next = val + 32'sd1;
          end
        end else if (ptr == count) begin
          // ran off the end of the table
          res_index_next = POS_W'(count);
          state_next     = ST_DONE;
        end
      end

      ST_SHIFT: begin
        // complete the move whose read was issued last cycle
        if (pend) begin
          we = 1'b1;
        end
        if (cmd_r == CMD_INSERT) begin
          if (ptr > pos_r) begin
            ra             = AW'(ptr - 1'b1);
            pend_next      = 1'b1;
            pend_addr_next = AW'(ptr);
            ptr_next       = ptr - 1'b1;
          end else if (!pend) begin
            we         = 1'b1;
            wa         = AW'(pos_r);
            wd         = key_r;
            count_next = count + 1'b1;
            state_next = ST_DONE;
          end
        end else begin
          if ((CW + 1)'(ptr) + 1'b1 < (CW + 1)'(count)) begin
            ra             = AW'(ptr + 1'b1);
            pend_next      = 1'b1;
            pend_addr_next = AW'(ptr);
            ptr_next       = ptr + 1'b1;
          end else if (!pend) begin
            count_next = count - 1'b1;
            state_next = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_found_next  = res_found;
          out_index_next  = res_index;
          out_value_next  = (cmd_r == CMD_GAP) ? val : 32'sd0;
          out_status_next = res_status;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rsp.valid      = out_valid;
  assign rsp.found      = out_found;
  assign rsp.index      = out_index;
  assign rsp.next_value = out_value;
  assign rsp.status     = out_status;

endmodule
`default_nettype wire

FILE: test/table_checker.sv
`timescale 1ns / 100ps
// Checker for the sorted table block: predicts each command result and compares it.
module table_checker
  import stsid_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  stsid_req_if               req,
  stsid_rsp_if               rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output int                 errors,
  output int                 pending,
  output int                 checked
);

  localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'(4 * REG_CAP_IDX);

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   index;
    logic signed [31:0] next_value;
    logic [1:0]         status;
  } table_answer_t;

  // Predicted table contents, count and capacity setting
  logic signed [31:0] table_words [DEPTH];
  int                 entry_total;
  logic [8:0]         cap_limit;
  table_answer_t      awaited_results [$];

  // Runs one command on the predicted table and returns its result
  function automatic table_answer_t apply_command(input logic [1:0] cmd,
                                                  input logic signed [31:0] key,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic signed [31:0] start);
    table_answer_t      ans;
    int                 n;
    int                 lim;
    int                 i;
    logic               hit;
    logic signed [31:0] run;
    ans = '0;
    n = entry_total;
    hit = 1'b0;
    run = start;
    case (cmd)
      CMD_SEARCH: begin
        ans.index = POS_W'(n);
        for (i = 0; i < n && !hit; i++) begin
          if (table_words[i] >= key) begin
            hit = 1'b1;
            ans.index = POS_W'(i);
            ans.found = (table_words[i] == key);
          end
        end
      end
      CMD_GAP: begin
        ans.index = POS_W'(n);
        for (i = 0; i < n && !hit; i++) begin
          if (run < table_words[i]) begin
            hit = 1'b1;
            ans.index = POS_W'(i);
          end else begin
            run = run + 32'sd1;   // wraps at the top of the range
          end
        end
        ans.next_value = run;
      end
      CMD_INSERT: begin
        lim = (cap_limit > DEPTH) ? DEPTH : cap_limit;
        // full is tested before the position
        if (n >= lim) begin
          ans.status = STATUS_FULL;
        end else if (pos > n) begin
          ans.status = STATUS_RANGE;
        end else begin
          for (i = n; i > pos; i--) table_words[i] = table_words[i-1];
          table_words[pos] = key;
          entry_total = n + 1;
        end
      end
      default: begin
        if (pos >= n) begin
          ans.status = STATUS_RANGE;
        end else begin
          for (i = pos; i + 1 < n; i++) table_words[i] = table_words[i+1];
          entry_total = n - 1;
        end
      end
    endcase
    return ans;
  endfunction

  // Results are taken before commands so a same-edge accept cannot match itself
  always @(posedge clk) begin
    table_answer_t want;
    if (rst) begin
      entry_total = 0;
      cap_limit = CAP_RESET;
      awaited_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result item with no command outstanding: index %0d status %0d",
                 rsp.index, rsp.status);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          checked++;
          if (rsp.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, rsp.found);
            errors++;
          end
          if (rsp.index !== want.index) begin
            $error("index: expected %0d, actual %0d", want.index, rsp.index);
            errors++;
          end
          if (rsp.next_value !== want.next_value) begin
            $error("next_value: expected %0d, actual %0d",
                   $signed(want.next_value), $signed(rsp.next_value));
            errors++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            errors++;
          end
        end
      end
      if (req.valid && req.ready)
        awaited_results.push_back(apply_command(req.cmd, req.key, req.position,
                                                req.start_value));
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
        cap_limit = pwdata[8:0];
    end
    pending <= awaited_results.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, command stimulus and verdict for the sorted table block.
module testbench;
  import stsid_pkg::*;

  localparam int unsigned        TABLE_DEPTH    = 256;
  localparam int                 WATCHDOG_LIMIT = 5000;
  localparam int                 LONG_HOLD      = 300;
  localparam logic [PADDR_W-1:0] CAP_ADDR       = PADDR_W'(4 * REG_CAP_IDX);

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  stsid_req_if req ();
  stsid_rsp_if rsp ();

  int errors;
  int pending;
  int checked;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int holds_done;
  int hold_left;
  int idle_cycles;
  int cmd_total [4];
  int cap_now;
  int stim_table [$];   // stimulus-side copy of the table, for picking positions and keys

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_table_search_insert_delete #(.DEPTH(TABLE_DEPTH)) u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  table_checker #(.DEPTH(TABLE_DEPTH)) u_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending),
    .checked (checked)
  );

  // Result side: random stalls, plus a long hold whenever one is requested
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      rsp.ready <= 1'b0;
      hold_left <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: cycles without any item moving
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("** sorted_table_search_insert_delete: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one command item and waits for it to be taken
  task automatic send(input logic [1:0] cmd, input logic signed [31:0] key,
                      input logic [POS_W-1:0] pos, input logic signed [31:0] start);
    int lim;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.key <= key;
    req.position <= pos;
    req.start_value <= start;
    do @(posedge clk); while (!req.ready);
    cmd_total[cmd]++;
    lim = (cap_now > TABLE_DEPTH) ? TABLE_DEPTH : cap_now;
    if (cmd == CMD_INSERT && stim_table.size() < lim && pos <= stim_table.size())
      stim_table.insert(int'(pos), key);
    else if (cmd == CMD_DELETE && pos < stim_table.size())
      stim_table.delete(int'(pos));
  endtask

  // Stops offering and waits until every result has come back
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input int value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap_now = value;
  endtask

  // Mostly well-formed commands against a table kept near a target size
  task automatic random_item(input int target);
    logic [1:0]         cmd;
    logic signed [31:0] key;
    logic signed [31:0] start;
    logic [POS_W-1:0]   pos;
    int                 sz;
    int                 roll;
    int                 i;
    sz = stim_table.size();
    cmd = 2'($urandom_range(3));
    key = $urandom;
    start = $urandom;
    pos = POS_W'($urandom_range(511));
    roll = $urandom_range(99);
    if (roll >= 10) begin
      roll = $urandom_range(99);
      if (roll < 35) cmd = (sz < target) ? CMD_INSERT : CMD_DELETE;
      else if (roll < 50) cmd = (sz < target) ? CMD_DELETE : CMD_INSERT;
      else if (roll < 75) cmd = CMD_SEARCH;
      else cmd = CMD_GAP;
      case (cmd)
        CMD_INSERT: begin
          // small keys give duplicates and runs of consecutive values
          if ($urandom_range(4) != 0) key = $urandom_range(80) - 40;
          pos = '0;
          while (pos < sz && stim_table[pos] < key) pos++;
        end
        CMD_DELETE: begin
          if (sz > 0) pos = POS_W'($urandom_range(sz - 1));
        end
        CMD_SEARCH: begin
          if (sz > 0 && $urandom_range(1) == 0) key = stim_table[$urandom_range(sz - 1)];
          else if ($urandom_range(1) == 0) key = $urandom_range(80) - 40;
        end
        default: begin
          i = (sz > 0) ? $urandom_range(sz - 1) : 0;
          if ($urandom_range(9) == 0) start = 32'sh7fffffff - $urandom_range(3);
          else if (sz > 0) start = stim_table[i] - i - $urandom_range(1);
        end
      endcase
    end
    send(cmd, key, pos, start);
  endtask

  task automatic random_phase(input int count, input int target, input int hold_at,
                              input int pause_at);
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) hold_requests <= hold_requests + 1;
      if (k == pause_at) drain();
      random_item(target);
    end
  endtask

  initial begin
    logic signed [31:0] fill_key;
    rst = 1'b1;
    req.valid = 1'b0;
    req.cmd = CMD_SEARCH;
    req.key = '0;
    req.position = '0;
    req.start_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cap_now = CAP_RESET;
    send_idle_pct = 8;
    recv_idle_pct = 51;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty table: scans end at once, delete and a far insert are out of range
    send(CMD_SEARCH, 0, 0, 0);
    send(CMD_GAP, 0, 0, 5);
    send(CMD_DELETE, 0, 0, 0);
    send(CMD_INSERT, 3, 1, 0);
    // Field extremes in the table
    send(CMD_INSERT, 32'sh80000000, 0, 0);
    send(CMD_INSERT, 32'sh7fffffff, 1, 0);
    send(CMD_INSERT, 0, 1, 0);
    send(CMD_SEARCH, 32'sh80000000, 0, 0);
    send(CMD_SEARCH, 32'sh7fffffff, 0, 0);
    send(CMD_SEARCH, -5, 0, 0);
    // Running value wraps from the top to the bottom of the range
    send(CMD_GAP, 0, 0, 32'sh7fffffff);
    send(CMD_GAP, 0, 0, 32'sh80000000);
    // Positions past the count, with the top position bit set
    send(CMD_DELETE, 0, 256, 0);
    send(CMD_DELETE, 0, 3, 0);
    send(CMD_INSERT, 9, 4, 0);
    send(CMD_INSERT, 9, 511, 0);
    // Unsorted table: scans run on whatever order is held
    send(CMD_INSERT, 100, 0, 0);
    send(CMD_SEARCH, 50, 0, 0);
    send(CMD_GAP, 0, 0, 200);
    send(CMD_DELETE, 0, 0, 0);
    send(CMD_DELETE, 0, 2, 0);
    send(CMD_SEARCH, -1, 511, 32'shffffffff);

    // Capacity below the count: insert is full (even at a bad position), delete works
    set_capacity(0);
    send(CMD_INSERT, 7, 0, 0);
    send(CMD_INSERT, 7, 400, 0);
    send(CMD_DELETE, 0, 1, 0);
    set_capacity(1);
    send(CMD_INSERT, 7, 0, 0);
    send(CMD_DELETE, 0, 0, 0);
    send(CMD_INSERT, 7, 0, 0);
    send(CMD_INSERT, 8, 1, 0);

    set_capacity(TABLE_DEPTH);
    random_phase(500, 20, 100, 250);

    send_idle_pct = 51;
    recv_idle_pct = 8;
    set_capacity($urandom_range(40, 255));
    random_phase(500, 40, 150, 350);

    // Fill to the full depth by appending, then work at the full table
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_capacity(TABLE_DEPTH);
    while (stim_table.size() < TABLE_DEPTH) begin
      if (stim_table.size() == 0) begin
        fill_key = -300;
      end else begin
        fill_key = stim_table[$];
        if (fill_key < 32'sh7fff0000) fill_key = fill_key + $urandom_range(1);
      end
      send(CMD_INSERT, fill_key, POS_W'(stim_table.size()), $urandom);
    end
    send(CMD_INSERT, 5, 0, 0);
    send(CMD_SEARCH, stim_table[$], 0, 0);
    send(CMD_SEARCH, 32'sh7fffffff, 0, 0);
    send(CMD_GAP, 0, 0, stim_table[0]);
    send(CMD_DELETE, 0, 0, 0);
    send(CMD_INSERT, 32'sh80000000, 0, 0);
    send(CMD_GAP, 0, 0, 32'sh80000000);

    // Lower the capacity under a full table and shrink it from the end
    set_capacity(16);
    send(CMD_INSERT, 5, 0, 0);
    while (stim_table.size() > 12)
      send(CMD_DELETE, $urandom, POS_W'(stim_table.size() - 1), $urandom);
    send(CMD_INSERT, 5, 0, 0);

    set_capacity(TABLE_DEPTH);
    random_phase(450, 60, 200, -1);

    drain();
    repeat (16) @(posedge clk);
    $display("Run covered %0d search, %0d insert, %0d delete and %0d first gap commands;",
             cmd_total[CMD_SEARCH], cmd_total[CMD_INSERT], cmd_total[CMD_DELETE],
             cmd_total[CMD_GAP]);
    $display("%0d results checked, capacity set from 0 up to a full %0d-entry table.",
             checked, TABLE_DEPTH);
    if (errors == 0) begin
      $display("** sorted_table_search_insert_delete: PASSED **");
    end else begin
      $display("** sorted_table_search_insert_delete: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sorted_table_search_insert_delete.f
design/stsid_pkg.sv
design/stsid_if.sv
design/sorted_table_search_insert_delete.sv
test/table_checker.sv
test/testbench.sv
